// ===== src/tccs_pkg.sv =====
// ----------------------------------------------------------------------------
// tccs_pkg: shared types and constants of the text console engine
// Item layouts, controller/datapath command and status groups, state codes
// and the character codes the console interprets.
// ----------------------------------------------------------------------------
package tccs_pkg;

  // Character codes with special handling
  localparam logic [7:0] CH_NEWLINE   = 8'h0A;
  localparam logic [7:0] CH_BACKSPACE = 8'h08;
  localparam logic [7:0] CH_TAB       = 8'h09;
  localparam logic [7:0] CH_SPACE     = 8'h20;

  localparam int unsigned TAB_ADVANCE = 4;
  localparam int unsigned BACK_MARGIN = 2;

  // Screen cell after reset: blank, grey on black
  localparam logic [15:0] BLANK_CELL = 16'h0720;

  // Configuration register indexes and reset values
  localparam logic       REG_TEXT_COLOR    = 1'b0;
  localparam logic       REG_PROMPT_LENGTH = 1'b1;
  localparam logic [7:0] TEXT_COLOR_RESET  = 8'd7;
  localparam logic [6:0] PROMPT_RESET      = 7'd0;

  // Request function codes
  localparam logic FUNC_PUT  = 1'b0;
  localparam logic FUNC_READ = 1'b1;

  typedef struct packed {
    logic        func;
    logic [7:0]  char_code;
    logic [10:0] cell_index;
  } in_item_t;

  typedef struct packed {
    logic [4:0]  cursor_row;
    logic [6:0]  cursor_col;
    logic [15:0] cell_value;
    logic        scrolled;
  } out_item_t;

  // Controller to datapath
  typedef struct packed {
    logic load;    // latch the accepted request
    logic step;    // control-character / tab pre-move
    logic write;   // write the character cell, advance cursor
    logic scroll;  // one step of the scroll walk
    logic read;    // issue the screen read
    logic clear;   // one step of the post-reset clearing pass
    logic emit;    // load the result register
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic func;
    logic is_nl;
    logic is_bs;
    logic tab_wrap;
    logic last_row;
    logic col_wrap;
    logic scroll_done;
    logic clear_done;
    logic out_busy;
  } status_t;

  typedef enum logic [6:0] {
    S_CLEAR  = 7'b0000001,
    S_IDLE   = 7'b0000010,
    S_STEP   = 7'b0000100,
    S_WRITE  = 7'b0001000,
    S_SCROLL = 7'b0010000,
    S_READ   = 7'b0100000,
    S_DONE   = 7'b1000000
  } state_t;

endpackage

// ===== src/tccs_in_if.sv =====
// ----------------------------------------------------------------------------
// tccs_in_if: request channel of the text console engine
// Valid/ready channel carrying one request (put character or read cell).
// ----------------------------------------------------------------------------
interface tccs_in_if;
  logic               valid;
  logic               ready;
  tccs_pkg::in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== src/tccs_out_if.sv =====
// ----------------------------------------------------------------------------
// tccs_out_if: result channel of the text console engine
// Valid/ready channel carrying one result per request.
// ----------------------------------------------------------------------------
interface tccs_out_if;
  logic                valid;
  logic                ready;
  tccs_pkg::out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== src/tccs_ram.sv =====
// ----------------------------------------------------------------------------
// tccs_ram: generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module tccs_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== src/tccs_ctrl.sv =====
// ----------------------------------------------------------------------------
// tccs_ctrl: sequencer of the text console engine
// Walks each request through step, write, scroll and read phases and runs
// the clearing pass after reset.
// ----------------------------------------------------------------------------
module tccs_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  tccs_pkg::status_t st,
  output tccs_pkg::cmd_t    cmd
);
  import tccs_pkg::*;

  state_t state_r, state_nxt;
  logic   write_after_r, write_after_nxt;  // scroll came from a tab wrap

  always_comb begin
    state_nxt       = state_r;
    write_after_nxt = write_after_r;
    cmd             = '0;
    in_ready        = 1'b0;
    unique case (state_r)
      S_CLEAR: begin
        cmd.clear = 1'b1;
        if (st.clear_done) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_STEP;
        end
      end
      S_STEP: begin
        if (st.func) begin
          cmd.read  = 1'b1;
          state_nxt = S_READ;
        end else begin
          cmd.step = 1'b1;
          priority if (st.is_nl) begin
            write_after_nxt = 1'b0;
            state_nxt       = st.last_row ? S_SCROLL : S_DONE;
          end else if (st.is_bs) begin
            state_nxt = S_DONE;
          end else if (st.tab_wrap && st.last_row) begin
            write_after_nxt = 1'b1;
            state_nxt       = S_SCROLL;
          end else begin
            state_nxt = S_WRITE;
          end
        end
      end
      S_WRITE: begin
        cmd.write = 1'b1;
        if (st.col_wrap && st.last_row) begin
          write_after_nxt = 1'b0;
          state_nxt       = S_SCROLL;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_SCROLL: begin
        cmd.scroll = 1'b1;
        if (st.scroll_done) begin
          state_nxt = write_after_r ? S_WRITE : S_DONE;
        end
      end
      S_READ: begin
        // read data, issued in the step state, sits in the RAM output register here
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!st.out_busy) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_CLEAR;
      write_after_r <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      write_after_r <= write_after_nxt;
    end
  end

endmodule

// ===== src/tccs_dp.sv =====
// ----------------------------------------------------------------------------
// tccs_dp: datapath of the text console engine
// Cursor registers, screen memory with its address generation, the shared
// walk counter and the result register.
// ----------------------------------------------------------------------------
module tccs_dp #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic               clk,
  input  logic               rst_n,
  input  tccs_pkg::in_item_t in_item,
  input  tccs_pkg::cmd_t     cmd,
  output tccs_pkg::status_t  st,
  input  logic [7:0]         text_color,
  input  logic [6:0]         prompt_length,
  tccs_out_if.source         out_if
);
  import tccs_pkg::*;

  localparam int CELLS  = ROWS * COLUMNS;
  localparam int ADDR_W = $clog2(CELLS);
  localparam int CNT_W  = $clog2(CELLS + 1);
  localparam int COL_W  = $clog2(COLUMNS);
  localparam int ROW_W  = $clog2(ROWS);

  logic [ROW_W-1:0] row_r, row_nxt;
  logic [COL_W-1:0] col_r, col_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             scrolled_r, scrolled_nxt;
  logic             rd_ok_r, rd_ok_nxt;
  logic             rd_fresh_r, rd_fresh_nxt;
  logic             out_valid_r, out_valid_nxt;
  in_item_t         item_r;
  out_item_t        out_data_r;

  logic              we, re;
  logic [ADDR_W-1:0] waddr, raddr;
  logic [15:0]       wdata, rdata;

  logic [ADDR_W-1:0] row_base, cell_addr;
  logic [COL_W:0]    col_plus4;
  logic [CNT_W:0]    src_sum;
  logic [CNT_W-1:0]  cnt_dec;
  logic              src_ok, idx_ok, bs_back;
  logic [ROW_W-1:0]  row_inc;

  assign row_base  = ADDR_W'(row_r) * ADDR_W'(COLUMNS);
  assign cell_addr = row_base + ADDR_W'(col_r);
  assign col_plus4 = {1'b0, col_r} + (COL_W+1)'(TAB_ADVANCE);
  assign src_sum   = {1'b0, cnt_r} + (CNT_W+1)'(COLUMNS);
  assign src_ok    = src_sum < (CNT_W+1)'(CELLS);
  assign cnt_dec   = cnt_r - CNT_W'(1);
  assign idx_ok    = 32'(item_r.cell_index) < 32'(CELLS);
  assign bs_back   = 8'(col_r) > ({1'b0, prompt_length} + 8'(BACK_MARGIN));
  assign row_inc   = st.last_row ? row_r : row_r + ROW_W'(1);

  assign st.func        = item_r.func == FUNC_READ;
  assign st.is_nl       = item_r.char_code == CH_NEWLINE;
  assign st.is_bs       = item_r.char_code == CH_BACKSPACE;
  assign st.tab_wrap    = (item_r.char_code == CH_TAB) &&
                          (col_plus4 >= (COL_W+1)'(COLUMNS));
  assign st.last_row    = row_r == ROW_W'(ROWS - 1);
  assign st.col_wrap    = col_r == COL_W'(COLUMNS - 1);
  assign st.scroll_done = cnt_r == CNT_W'(CELLS);
  assign st.clear_done  = cnt_r == CNT_W'(CELLS - 1);
  assign st.out_busy    = out_valid_r && !out_if.ready;

  always_comb begin
    row_nxt       = row_r;
    col_nxt       = col_r;
    cnt_nxt       = cnt_r;
    scrolled_nxt  = scrolled_r;
    rd_ok_nxt     = rd_ok_r;
    rd_fresh_nxt  = 1'b0;
    out_valid_nxt = out_valid_r && !out_if.ready;
    we            = 1'b0;
    waddr         = '0;
    wdata         = '0;
    re            = 1'b0;
    raddr         = '0;

    if (cmd.load) begin
      scrolled_nxt = 1'b0;
      rd_ok_nxt    = 1'b0;
    end

    if (cmd.clear) begin
      we      = 1'b1;
      waddr   = cnt_r[ADDR_W-1:0];
      wdata   = BLANK_CELL;
      cnt_nxt = st.clear_done ? '0 : cnt_r + CNT_W'(1);
    end

    if (cmd.read) begin
      rd_ok_nxt = idx_ok;
      re        = idx_ok;
      raddr     = ADDR_W'(item_r.cell_index);
    end

    if (cmd.step) begin
      priority if (st.is_nl) begin
        col_nxt = '0;
        row_nxt = row_inc;
      end else if (st.is_bs) begin
        if (col_r != '0) begin
          we    = 1'b1;
          waddr = cell_addr - ADDR_W'(1);
          wdata = {text_color, CH_SPACE};
        end
        // moving back from above prompt+2 never lands at or below the prompt
        if (bs_back) begin
          col_nxt = col_r - COL_W'(1);
        end
      end else if (st.tab_wrap) begin
        col_nxt = '0;
        row_nxt = row_inc;
      end else if (item_r.char_code == CH_TAB) begin
        col_nxt = col_plus4[COL_W-1:0];
      end
    end

    if (cmd.write) begin
      we    = 1'b1;
      waddr = cell_addr;
      wdata = {text_color, item_r.char_code};
      if (st.col_wrap) begin
        col_nxt = '0;
        row_nxt = row_inc;
      end else begin
        col_nxt = col_r + COL_W'(1);
      end
    end

    // Scroll walk: read cell cnt+COLUMNS, write it to the cell one row up in the
    // following cycle; reads past the end turn into bottom-row blanks.
    if (cmd.scroll) begin
      scrolled_nxt = 1'b1;
      re           = src_ok;
      raddr        = src_sum[ADDR_W-1:0];
      rd_fresh_nxt = src_ok;
      if (cnt_r != '0) begin
        we    = 1'b1;
        waddr = cnt_dec[ADDR_W-1:0];
        wdata = rd_fresh_r ? {text_color, rdata[7:0]} : {text_color, CH_SPACE};
      end
      cnt_nxt = st.scroll_done ? '0 : cnt_r + CNT_W'(1);
    end

    if (cmd.emit) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r       <= '0;
      col_r       <= '0;
      cnt_r       <= '0;
      scrolled_r  <= 1'b0;
      rd_ok_r     <= 1'b0;
      rd_fresh_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      row_r       <= row_nxt;
      col_r       <= col_nxt;
      cnt_r       <= cnt_nxt;
      scrolled_r  <= scrolled_nxt;
      rd_ok_r     <= rd_ok_nxt;
      rd_fresh_r  <= rd_fresh_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item_r <= in_item;
    end
    if (cmd.emit) begin
      out_data_r.cursor_row <= 5'(row_r);
      out_data_r.cursor_col <= 7'(col_r);
      out_data_r.cell_value <= rd_ok_r ? rdata : 16'h0000;
      out_data_r.scrolled   <= scrolled_r;
    end
  end

  assign out_if.valid = out_valid_r;
  assign out_if.data  = out_data_r;

  tccs_ram #(
    .WIDTH (16),
    .DEPTH (CELLS)
  ) u_screen (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (re),
    .raddr (raddr),
    .rdata (rdata)
  );

endmodule

// ===== src/text_console_cursor_scroll_top.sv =====
// ----------------------------------------------------------------------------
// text_console_cursor_scroll_top: character-cell text console engine
// Sequence: printable characters, tabs and reads pass from accept to the next
//   accept through step, write or read, and result; newline and backspace skip the write.
// A scroll adds the screen walk, which moves one cell per cycle through the
//   single-port-pair screen RAM.
// Reset: synchronous, active low; a clearing pass over all ROWS*COLUMNS cells
//   follows, with in_if.ready low. Config writes still land.
// ----------------------------------------------------------------------------
module text_console_cursor_scroll_top #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic        clk,
  input  logic        rst_n,
  tccs_in_if.sink     in_if,
  tccs_out_if.source  out_if,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import tccs_pkg::*;

  // Configuration registers: text color at 0x0, prompt length at 0x4
  logic [7:0] text_color_r;
  logic [6:0] prompt_length_r;
  logic       cfg_wr;

  status_t st;
  cmd_t    cmd;
  logic    in_ready;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      text_color_r    <= TEXT_COLOR_RESET;
      prompt_length_r <= PROMPT_RESET;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        REG_TEXT_COLOR:    text_color_r    <= pwdata[7:0];
        REG_PROMPT_LENGTH: prompt_length_r <= pwdata[6:0];
        default: ;
      endcase
    end
  end

  // Register read-back, decoded on the word index
  always_comb begin
    unique case (paddr[2])
      REG_TEXT_COLOR:    prdata = {24'h000000, text_color_r};
      REG_PROMPT_LENGTH: prdata = {25'h0000000, prompt_length_r};
      default:           prdata = '0;
    endcase
  end

  // Sequencer: accepts a request only when idle; the datapath result
  // register lets a new request in while the last result still waits.
  tccs_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_if.valid),
    .in_ready (in_ready),
    .st       (st),
    .cmd      (cmd)
  );

  assign in_if.ready = in_ready;

  // Datapath: cursor, screen RAM, scroll/clear walk and result register
  tccs_dp #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_item       (in_if.data),
    .cmd           (cmd),
    .st            (st),
    .text_color    (text_color_r),
    .prompt_length (prompt_length_r),
    .out_if        (out_if)
  );

endmodule
